FILE: hw/rtl/gsa_pkg.sv
// shared types and constants of the generational slot allocator
package gsa_pkg;

    // item actions
    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    // result status codes
    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_FULL       = 3'd1,
        STS_WRONG_TYPE = 3'd2,
        STS_BAD_INDEX  = 3'd3,
        STS_TOO_OLD    = 3'd4,
        STS_TOO_NEW    = 3'd5,
        STS_NOT_IN_USE = 3'd6
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_POOL_TYPE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ITEM_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ITEM_SIZE  = 2'd2;

    localparam int CFG_DATA_W   = 16;
    localparam int COUNT_W      = 11;
    localparam int GEN_W        = 16;
    localparam int TYPE_W       = 16;
    localparam int SIZE_W       = 16;
    localparam int SLOT_INDEX_W = 10;
    localparam int OFFSET_W     = 26;

    localparam logic [COUNT_W-1:0] ITEM_COUNT_RESET = 11'd1024;
    localparam logic [SIZE_W-1:0]  ITEM_SIZE_RESET  = 16'd1;

    // request item
    typedef struct packed {
        action_t            action;
        logic [31:0]        handle_index;
        logic [GEN_W-1:0]   handle_generation;
        logic [TYPE_W-1:0]  handle_type;
    } req_item_t;

    // result item
    typedef struct packed {
        status_t                  status;
        logic [SLOT_INDEX_W-1:0]  slot_index;
        logic [GEN_W-1:0]         slot_generation;
        logic [TYPE_W-1:0]        slot_type;
        logic [OFFSET_W-1:0]      byte_offset;
    } rsp_item_t;

    // per-slot entry of the slot memory
    typedef struct packed {
        logic              used;
        logic [GEN_W-1:0]  gen;
    } slot_t;

endpackage

FILE: hw/rtl/gsa_ram.sv
// generic single-write, single-read ram with registered read data
module gsa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]          wr_data,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/gsa_check.sv
// handle check and result formation for allocate, free and look up
module gsa_check #(
    parameter int MAX_SLOTS = 1024
) (
    input  gsa_pkg::req_item_t                       item,
    input  logic [$clog2(MAX_SLOTS)-1:0]             head,
    input  logic [((($clog2(MAX_SLOTS)+1) > 11) ?
                   ($clog2(MAX_SLOTS)+1) : 11)-1:0]  eff_n,
    input  logic [gsa_pkg::TYPE_W-1:0]               pool_type,
    input  logic [gsa_pkg::SIZE_W-1:0]               item_size,
    input  gsa_pkg::slot_t                           slot,
    output gsa_pkg::rsp_item_t                       rsp,
    output logic                                     pass
);
    import gsa_pkg::*;

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int EW = ((IW + 1) > 11) ? (IW + 1) : 11;
    localparam int PW = IW + SIZE_W;

    logic [IW-1:0] idx;
    logic [PW-1:0] prod;

    // slot under work: head of the free list or the handle's slot
    assign idx  = (item.action == ACT_ALLOC) ? head : item.handle_index[IW-1:0];
    assign prod = PW'(idx) * PW'(item_size);

    // checks in priority order
    always_comb
    begin
        rsp  = '0;
        pass = 1'b0;
        case (item.action)
            ACT_ALLOC:
            begin
                if ((head == '0) || (EW'(head) >= eff_n))
                begin
                    rsp.status = STS_FULL;
                end
                else
                begin
                    pass                = 1'b1;
                    rsp.slot_index      = SLOT_INDEX_W'(idx);
                    rsp.slot_generation = slot.gen + 16'd1;
                    rsp.slot_type       = pool_type;
                    rsp.byte_offset     = OFFSET_W'(prod);
                end
            end
            ACT_FREE, ACT_LOOKUP:
            begin
                if (item.handle_type != pool_type)
                begin
                    rsp.status = STS_WRONG_TYPE;
                end
                else if (item.handle_index >= 32'(eff_n))
                begin
                    rsp.status = STS_BAD_INDEX;
                end
                else if (item.handle_generation < slot.gen)
                begin
                    rsp.status = STS_TOO_OLD;
                end
                else if (item.handle_generation > slot.gen)
                begin
                    rsp.status = STS_TOO_NEW;
                end
                else if (!slot.used)
                begin
                    rsp.status = STS_NOT_IN_USE;
                end
                else
                begin
                    pass                = 1'b1;
                    rsp.slot_index      = SLOT_INDEX_W'(idx);
                    rsp.slot_generation = slot.gen;
                    rsp.slot_type       = pool_type;
                    if (item.action == ACT_LOOKUP)
                    begin
                        rsp.byte_offset = OFFSET_W'(prod);
                    end
                end
            end
            default:
            begin
                rsp  = '0;
                pass = 1'b0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/generational_slot_allocator.sv
// top level of the generational slot allocator
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  req_item (action, handle)
//  rsp      out        rsp_valid / rsp_stall  rsp_item (status, handle, offset)
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// allocate, free and look up: the accept cycle reads the slot and link
// memories, then the exec state checks, writes back and loads the result.
// clear walks every slot of both memories, one a cycle; after reset the same
// pass rebuilds the free chain with req_stall high; configuration writes are
// taken throughout.
// a stalled result holds the finishing item in place until the register frees.
module generational_slot_allocator #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  gsa_pkg::req_item_t                  req_item,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output gsa_pkg::rsp_item_t                  rsp_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gsa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [gsa_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import gsa_pkg::*;

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int EW = ((IW + 1) > 11) ? (IW + 1) : 11;
    localparam int SW = $bits(slot_t);
    localparam logic [EW-1:0] MAX_N = EW'(MAX_SLOTS);
    localparam logic [EW-1:0] RESET_N =
        (EW'(ITEM_COUNT_RESET) > MAX_N) ? MAX_N : EW'(ITEM_COUNT_RESET);

    state_t             state_reg, state_next;
    req_item_t          item_reg;
    logic [IW-1:0]      head_reg, head_next;
    logic [IW-1:0]      clr_idx_reg, clr_idx_next;
    logic [EW-1:0]      clr_n_reg, clr_n_next;
    logic               clr_item_reg, clr_item_next;
    logic [TYPE_W-1:0]  pool_type_reg;
    logic [COUNT_W-1:0] item_count_reg;
    logic [SIZE_W-1:0]  item_size_reg;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_item_t          rsp_item_reg, rsp_item_next;

    logic               accept;
    logic               out_free;
    logic               clr_last;
    logic [EW-1:0]      eff_n;
    logic [IW-1:0]      exec_idx;
    logic [IW-1:0]      clr_link;

    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               slot_wr_en;
    logic               link_wr_en;
    logic [IW-1:0]      wr_addr;
    slot_t              slot_wr_data;
    logic [IW-1:0]      link_wr_data;
    logic [SW-1:0]      slot_rd_raw;
    slot_t              slot_rd;
    logic [IW-1:0]      link_rd;

    rsp_item_t          chk_rsp;
    logic               chk_pass;

    // handshake terms
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign clr_last  = (clr_idx_reg == IW'(MAX_SLOTS - 1));
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // effective slot count, capped at the memory depth
    assign eff_n = (EW'(item_count_reg) > MAX_N) ? MAX_N : EW'(item_count_reg);

    // slot of the item under execution
    assign exec_idx = (item_reg.action == ACT_ALLOC) ? head_reg
                                                     : item_reg.handle_index[IW-1:0];

    // free chain link rebuilt by the clear walk
    assign clr_link = ((clr_idx_reg != '0) && ((EW'(clr_idx_reg) + EW'(1)) < clr_n_reg))
                      ? IW'(clr_idx_reg + IW'(1)) : '0;

    // per-slot in-use mark and generation
    gsa_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_wr_en),
        .wr_addr (wr_addr),
        .wr_data (slot_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (slot_rd_raw)
    );

    assign slot_rd = slot_t'(slot_rd_raw);

    // per-slot free list link
    gsa_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_SLOTS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (link_rd)
    );

    // handle check on the read-back slot
    gsa_check #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_check (
        .item      (item_reg),
        .head      (head_reg),
        .eff_n     (eff_n),
        .pool_type (pool_type_reg),
        .item_size (item_size_reg),
        .slot      (slot_rd),
        .rsp       (chk_rsp),
        .pass      (chk_pass)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req_item.action == ACT_CLEAR) ? ST_CLEAR : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                if (clr_last && (!clr_item_reg || out_free))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory controls and request stall
    always_comb
    begin
        req_stall    = 1'b1;
        rd_en        = 1'b0;
        rd_addr      = (req_item.action == ACT_ALLOC) ? head_reg
                                                      : req_item.handle_index[IW-1:0];
        slot_wr_en   = 1'b0;
        link_wr_en   = 1'b0;
        wr_addr      = exec_idx;
        slot_wr_data = '0;
        link_wr_data = head_reg;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                rd_en     = req_valid && (req_item.action != ACT_CLEAR);
            end
            ST_EXEC:
            begin
                if (out_free && chk_pass)
                begin
                    case (item_reg.action)
                        ACT_ALLOC:
                        begin
                            slot_wr_en   = 1'b1;
                            slot_wr_data = '{used: 1'b1, gen: chk_rsp.slot_generation};
                        end
                        ACT_FREE:
                        begin
                            slot_wr_en   = 1'b1;
                            link_wr_en   = 1'b1;
                            slot_wr_data = '{used: 1'b0, gen: slot_rd.gen};
                        end
                        default:
                        begin
                            slot_wr_en = 1'b0;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                slot_wr_en   = 1'b1;
                link_wr_en   = 1'b1;
                wr_addr      = clr_idx_reg;
                slot_wr_data = '0;
                link_wr_data = clr_link;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // datapath register updates
    always_comb
    begin
        head_next      = head_reg;
        clr_idx_next   = clr_idx_reg;
        clr_n_next     = clr_n_reg;
        clr_item_next  = clr_item_reg;
        rsp_item_next  = rsp_item_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_item.action == ACT_CLEAR))
                begin
                    clr_idx_next  = '0;
                    clr_n_next    = eff_n;
                    clr_item_next = 1'b1;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_item_next  = chk_rsp;
                    if (chk_pass && (item_reg.action == ACT_ALLOC))
                    begin
                        head_next = link_rd;
                    end
                    else if (chk_pass && (item_reg.action == ACT_FREE))
                    begin
                        head_next = exec_idx;
                    end
                end
            end
            ST_CLEAR:
            begin
                if (!clr_last)
                begin
                    clr_idx_next = clr_idx_reg + IW'(1);
                end
                else if (!clr_item_reg || out_free)
                begin
                    head_next     = (clr_n_reg >= EW'(2)) ? IW'(1) : '0;
                    clr_item_next = 1'b0;
                    if (clr_item_reg)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_item_next  = '0;
                    end
                end
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            head_reg      <= '0;
            clr_idx_reg   <= '0;
            clr_n_reg     <= RESET_N;
            clr_item_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            clr_idx_reg   <= clr_idx_next;
            clr_n_reg     <= clr_n_next;
            clr_item_reg  <= clr_item_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_type_reg  <= '0;
            item_count_reg <= ITEM_COUNT_RESET;
            item_size_reg  <= ITEM_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POOL_TYPE:  pool_type_reg  <= cfg_data;
                CFG_ITEM_COUNT: item_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_ITEM_SIZE:  item_size_reg  <= cfg_data;
                default:        pool_type_reg  <= pool_type_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req_item;
        end
        rsp_item_reg <= rsp_item_next;
    end

    // an accepted item always leaves the idle state
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start execution");

    // a result appears only when execution or a clear walk finishes
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) != ST_IDLE))
        else $error("result raised without a finishing item");

    // memory reads and write-backs never overlap in one cycle
    a_no_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && (slot_wr_en || link_wr_en)))
        else $error("memory read and write in the same cycle");

endmodule

FILE: test/gsa_checker.sv
// checker for the slot allocator: mirrors the pool and compares every result item
module gsa_checker #(
    parameter int SLOTS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic                            req_stall,
    input  gsa_pkg::req_item_t              req_item,
    input  logic                            rsp_valid,
    input  logic                            rsp_stall,
    input  gsa_pkg::rsp_item_t              rsp_item,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [gsa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gsa_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatch_count,
    output int                              pending_count
);
    import gsa_pkg::*;

    // register copy
    logic [TYPE_W-1:0]       pool_tag;
    logic [COUNT_W-1:0]      pool_count;
    logic [SIZE_W-1:0]       pool_item_size;

    // pool copy
    logic                    slot_busy [SLOTS];
    logic [SLOT_INDEX_W-1:0] slot_link [SLOTS];
    logic [GEN_W-1:0]        slot_gen  [SLOTS];
    logic [SLOT_INDEX_W-1:0] free_head;

    rsp_item_t               awaited_rsp [$];
    int                      errors;

    // item count capped at the pool size
    function automatic logic [31:0] usable_count();
        return (pool_count > SLOTS) ? 32'(SLOTS) : 32'(pool_count);
    endfunction

    function automatic logic [OFFSET_W-1:0] offset_of(logic [SLOT_INDEX_W-1:0] idx);
        logic [31:0] prod;
        prod = 32'(idx) * 32'(pool_item_size);
        return prod[OFFSET_W-1:0];
    endfunction

    // zero all marks and generations, chain slots 1 to count-1
    function automatic void rebuild_pool();
        logic [31:0] n;
        n = usable_count();
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_busy[i] = 1'b0;
            slot_gen[i]  = '0;
            slot_link[i] = (i >= 1 && i + 1 < n) ? SLOT_INDEX_W'(i + 1) : '0;
        end
        free_head = (n >= 2) ? SLOT_INDEX_W'(1) : '0;
    endfunction

    // apply one request item to the pool copy and form its result
    function automatic rsp_item_t serve_request(req_item_t r);
        rsp_item_t               res;
        logic [31:0]             n;
        logic [SLOT_INDEX_W-1:0] idx;
        res = '0;
        n   = usable_count();
        case (r.action)
            ACT_CLEAR:
            begin
                rebuild_pool();
            end
            ACT_ALLOC:
            begin
                idx = free_head;
                if (idx == 0 || 32'(idx) >= n)
                begin
                    res.status = STS_FULL;
                end
                else
                begin
                    slot_busy[idx]      = 1'b1;
                    slot_gen[idx]       = slot_gen[idx] + 1'b1;
                    free_head           = slot_link[idx];
                    res.slot_index      = idx;
                    res.slot_generation = slot_gen[idx];
                    res.slot_type       = pool_tag;
                    res.byte_offset     = offset_of(idx);
                end
            end
            default:
            begin
                // free and look up share the handle checks, in priority order
                idx = r.handle_index[SLOT_INDEX_W-1:0];
                if (r.handle_type != pool_tag)
                    res.status = STS_WRONG_TYPE;
                else if (r.handle_index >= n)
                    res.status = STS_BAD_INDEX;
                else if (r.handle_generation < slot_gen[idx])
                    res.status = STS_TOO_OLD;
                else if (r.handle_generation > slot_gen[idx])
                    res.status = STS_TOO_NEW;
                else if (!slot_busy[idx])
                    res.status = STS_NOT_IN_USE;
                else
                begin
                    res.slot_index      = idx;
                    res.slot_generation = slot_gen[idx];
                    res.slot_type       = pool_tag;
                    if (r.action == ACT_FREE)
                    begin
                        slot_busy[idx] = 1'b0;
                        slot_link[idx] = free_head;
                        free_head      = idx;
                    end
                    else
                    begin
                        res.byte_offset = offset_of(idx);
                    end
                end
            end
        endcase
        return res;
    endfunction

    // watch all three channels
    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_item_t want;
        if (!rst_n)
        begin
            pool_tag       = '0;
            pool_count     = ITEM_COUNT_RESET;
            pool_item_size = ITEM_SIZE_RESET;
            rebuild_pool();
            awaited_rsp.delete();
            errors = 0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_POOL_TYPE:  pool_tag       = cfg_data[TYPE_W-1:0];
                    CFG_ITEM_COUNT: pool_count     = cfg_data[COUNT_W-1:0];
                    CFG_ITEM_SIZE:  pool_item_size = cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end

            // result items against the oldest expectation
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("gsa_checker: unexpected result item, status %0d index %0d",
                                 rsp_item.status, rsp_item.slot_index);
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp_item.status          !== want.status          ||
                        rsp_item.slot_index      !== want.slot_index      ||
                        rsp_item.slot_generation !== want.slot_generation ||
                        rsp_item.slot_type       !== want.slot_type       ||
                        rsp_item.byte_offset     !== want.byte_offset)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("gsa_checker: result mismatch: expected status %0d ",
                                     want.status, "index %0d gen %0d type %0h offset %0d; ",
                                     want.slot_index, want.slot_generation, want.slot_type,
                                     want.byte_offset, "got status %0d index %0d gen %0d ",
                                     rsp_item.status, rsp_item.slot_index,
                                     rsp_item.slot_generation, "type %0h offset %0d",
                                     rsp_item.slot_type, rsp_item.byte_offset);
                    end
                end
            end

            // request items
            if (req_valid && !req_stall)
                awaited_rsp.push_back(serve_request(req_item));
        end
        pending_count  <= awaited_rsp.size();
        mismatch_count <= errors;
    end

endmodule

FILE: test/generational_slot_allocator_tb.sv
// testbench top: stimulus and verdict for the generational slot allocator
module generational_slot_allocator_tb;
    import gsa_pkg::*;

    localparam int SLOTS       = 1024;
    localparam int QUIET_LIMIT = 6000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [31:0]      idx;
        logic [GEN_W-1:0] gen;
    } handle_t;

    typedef struct {
        action_t     act;
        int unsigned epoch;
    } sent_t;

    logic                   clk;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_stall;
    req_item_t              req_item;
    logic                   rsp_valid;
    logic                   rsp_stall;
    rsp_item_t              rsp_item;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatch_count;
    int                     pending_count;

    // stimulus state
    bit                     calm;
    bit                     hold_wanted;
    int unsigned            epoch;
    logic [TYPE_W-1:0]      cur_tag;
    logic [COUNT_W-1:0]     cur_count;
    handle_t                live_handles [$];
    handle_t                dead_handles [$];
    sent_t                  sent_actions [$];

    generational_slot_allocator #(.MAX_SLOTS(SLOTS)) DUT (.*);

    gsa_checker #(.SLOTS(SLOTS)) score (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, calm stretches and long hold-offs on request
    initial
    begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_wanted && hold_left == 0)
            begin
                hold_left   = HOLD_CYCLES;
                hold_wanted = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (calm)
                rsp_stall <= 1'b0;
            else
                rsp_stall <= ($urandom_range(99) < 37);
        end
    end

    // collect handles of successful allocations for later free and look up items
    always @(posedge clk)
    begin : harvest
        sent_t   s;
        handle_t h;
        if (rsp_valid && !rsp_stall && sent_actions.size() != 0)
        begin
            s = sent_actions.pop_front();
            if (s.act == ACT_ALLOC && s.epoch == epoch && rsp_item.status == STS_OK)
            begin
                h.idx = 32'(rsp_item.slot_index);
                h.gen = rsp_item.slot_generation;
                live_handles.push_back(h);
            end
        end
    end

    // watchdog on cycles with no item moving on any channel
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** generational_slot_allocator: FAILED **");
        $finish;
    end

    function automatic req_item_t make_req(action_t a, logic [31:0] i,
                                           logic [GEN_W-1:0] g, logic [TYPE_W-1:0] t);
        req_item_t it;
        it.action            = a;
        it.handle_index      = i;
        it.handle_generation = g;
        it.handle_type       = t;
        return it;
    endfunction

    // offer one request item, return at the edge that takes it
    task automatic send_req(input req_item_t it);
        while (!calm && $urandom_range(99) < 37)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        @(negedge clk);
        while (req_stall)
            @(negedge clk);
        @(posedge clk);
        sent_actions.push_back('{it.action, epoch});
    endtask

    // wait until every result item has come back
    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // write all three registers
    task automatic program_pool(input logic [TYPE_W-1:0] t, input logic [COUNT_W-1:0] c,
                                input logic [SIZE_W-1:0] s);
        logic [CFG_INDEX_W-1:0] regs [3];
        logic [CFG_DATA_W-1:0]  vals [3];
        regs = '{CFG_POOL_TYPE, CFG_ITEM_COUNT, CFG_ITEM_SIZE};
        vals = '{t, CFG_DATA_W'(c), s};
        for (int k = 0; k < 3; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            @(negedge clk);
            while (!cfg_ready)
                @(negedge clk);
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        cur_tag   = t;
        cur_count = c;
    endtask

    // mostly well-formed traffic on live handles, plus stale and broken handles
    function automatic req_item_t random_request();
        req_item_t   it;
        handle_t     h;
        int unsigned pick;
        int unsigned k;
        it = make_req(ACT_ALLOC, $urandom(), GEN_W'($urandom()), TYPE_W'($urandom()));
        pick = $urandom_range(99);
        if (pick < 1)
        begin
            it.action = ACT_CLEAR;
            epoch++;
            live_handles.delete();
            return it;
        end
        if (pick < 37)
            return it;
        it.action      = (pick < 70) ? ACT_FREE : ACT_LOOKUP;
        it.handle_type = cur_tag;
        pick = $urandom_range(99);
        if (pick < 76 && live_handles.size() != 0)
        begin
            k = $urandom_range(live_handles.size() - 1);
            h = live_handles[k];
            it.handle_index      = h.idx;
            it.handle_generation = h.gen;
            if (it.action == ACT_FREE)
            begin
                live_handles.delete(k);
                dead_handles.push_back(h);
                if (dead_handles.size() > 64)
                    void'(dead_handles.pop_front());
            end
        end
        else if (pick >= 76 && pick < 84 && dead_handles.size() != 0)
        begin
            h = dead_handles[$urandom_range(dead_handles.size() - 1)];
            it.handle_index      = h.idx;
            it.handle_generation = h.gen;
        end
        else if (pick >= 84 && pick < 88 && live_handles.size() != 0)
        begin
            // generation one off either way
            h = live_handles[$urandom_range(live_handles.size() - 1)];
            it.handle_index      = h.idx;
            it.handle_generation = $urandom_range(1) ? h.gen + 1'b1 : h.gen - 1'b1;
        end
        else if (pick >= 88 && pick < 91)
            it.handle_type = cur_tag ^ TYPE_W'($urandom_range(1, 16'hFFFF));
        else if (pick >= 91 && pick < 95)
            it.handle_index = $urandom_range(1) ? 32'($urandom_range(cur_count, 2047))
                                                : $urandom();
        else
        begin
            it.handle_index      = 32'($urandom_range(cur_count));
            it.handle_generation = GEN_W'($urandom_range(3));
        end
        return it;
    endfunction

    // main sequence
    initial
    begin : stimulus
        logic [TYPE_W-1:0]  tag;
        logic [COUNT_W-1:0] count;
        logic [SIZE_W-1:0]  size;
        int                 items;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_item    = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        calm        = 1'b0;
        hold_wanted = 1'b0;
        epoch       = 0;
        cur_tag     = '0;
        cur_count   = ITEM_COUNT_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, every handle check outcome, LIFO reuse, clear
        send_req(make_req(ACT_LOOKUP, 32'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_ALLOC, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        send_req(make_req(ACT_ALLOC, 32'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_LOOKUP, 32'd1, 16'd1, 16'd0));
        send_req(make_req(ACT_LOOKUP, 32'd2, 16'd1, 16'hFFFF));
        send_req(make_req(ACT_LOOKUP, 32'hFFFF_FFFF, 16'd1, 16'd0));
        send_req(make_req(ACT_FREE, 32'd1024, 16'd0, 16'd0));
        send_req(make_req(ACT_FREE, 32'd1, 16'd0, 16'd0));
        send_req(make_req(ACT_LOOKUP, 32'd1, 16'hFFFF, 16'd0));
        send_req(make_req(ACT_FREE, 32'd1, 16'd1, 16'd0));
        send_req(make_req(ACT_FREE, 32'd1, 16'd1, 16'd0));
        send_req(make_req(ACT_LOOKUP, 32'd1023, 16'd0, 16'd0));
        send_req(make_req(ACT_ALLOC, 32'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_LOOKUP, 32'd1, 16'd2, 16'd0));
        send_req(make_req(ACT_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        send_req(make_req(ACT_LOOKUP, 32'd1, 16'd2, 16'd0));
        send_req(make_req(ACT_ALLOC, 32'd0, 16'd0, 16'd0));

        // shrink the count without a clear: the free head is now out of range
        drain();
        program_pool(16'd0, 11'd2, 16'd1);
        send_req(make_req(ACT_ALLOC, 32'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_LOOKUP, 32'd1, 16'd1, 16'd0));
        send_req(make_req(ACT_LOOKUP, 32'd2, 16'd0, 16'd0));
        send_req(make_req(ACT_FREE, 32'd1, 16'd1, 16'd0));
        send_req(make_req(ACT_ALLOC, 32'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_ALLOC, 32'd0, 16'd0, 16'd0));

        // random phases over several register settings
        for (int p = 0; p < 8; p++)
        begin
            tag   = TYPE_W'($urandom());
            count = COUNT_W'($urandom_range(2, 40));
            size  = SIZE_W'($urandom_range(1, 65535));
            items = 240;
            case (p)
                0: begin count = 11'd1024; size = 16'hFFFF; items = 220; end
                1: begin tag = 16'hFFFF; count = 11'd2; size = 16'd1; items = 180; end
                2: begin tag = 16'd0; count = 11'd8; items = 200; end
                3: begin count = COUNT_W'($urandom_range(1)); items = 30; end
                4: begin count = 11'd2047; items = 200; end
                default: ;
            endcase
            drain();
            calm = (p == 2);
            program_pool(tag, count, size);
            epoch++;
            live_handles.delete();
            dead_handles.delete();
            send_req(make_req(ACT_CLEAR, $urandom(), GEN_W'($urandom()), TYPE_W'($urandom())));
            for (int n = 0; n < items; n++)
            begin
                if (n == 40 && (p == 0 || p == 5))
                    hold_wanted = 1'b1;
                send_req(random_request());
            end
        end

        // one usable slot, allocated and freed a few times
        drain();
        calm = 1'b1;
        program_pool(16'h5A3C, 11'd2, 16'd7);
        epoch++;
        send_req(make_req(ACT_CLEAR, 32'd0, 16'd0, 16'd0));
        for (int k = 1; k <= 6; k++)
        begin
            send_req(make_req(ACT_ALLOC, $urandom(), GEN_W'($urandom()), TYPE_W'($urandom())));
            send_req(make_req(ACT_FREE, 32'd1, GEN_W'(k), cur_tag));
        end
        send_req(make_req(ACT_ALLOC, 32'd0, 16'd0, 16'd0));
        send_req(make_req(ACT_LOOKUP, 32'd1, 16'd1, cur_tag));
        send_req(make_req(ACT_LOOKUP, 32'd1, 16'd0, cur_tag));
        send_req(make_req(ACT_LOOKUP, 32'd1, 16'hFFFF, cur_tag));

        // wind down and report
        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("** generational_slot_allocator: PASSED **");
        else
            $display("** generational_slot_allocator: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/gsa_pkg.sv
hw/rtl/gsa_ram.sv
hw/rtl/gsa_check.sv
hw/rtl/generational_slot_allocator.sv
test/gsa_checker.sv
test/generational_slot_allocator_tb.sv
